FILE: rtl/circular_deque_defines.svh
// Assertion macros used by the deque checker.
`ifndef CIRCULAR_DEQUE_DEFINES_SVH
`define CIRCULAR_DEQUE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CDQ_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("circular_deque: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CDQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("circular_deque: next-cycle check failed");

`endif

FILE: rtl/cdq_pkg.sv
package cdq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int OPCODE_W = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [OPCODE_W-1:0] OP_QUERY      = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [VALUE_W-1:0]  value;
    } deque_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
        logic [VALUE_W-1:0]  front_value;
        logic [VALUE_W-1:0]  back_value;
    } deque_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic read;
        logic load;
    } cdq_cmd_t;

endpackage

FILE: rtl/circular_deque.sv
// Double-ended queue in a ring memory with a head pointer and an element count.
// Each transaction runs the controller sequence update / registered memory read /
// output load, and no new one is accepted until the load; output stall delays it.
// Reset: head and count clear to an empty deque; memory contents are not cleared.
module circular_deque
    import cdq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  deque_in_t  in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output deque_out_t out_data
);

    cdq_cmd_t cmd;

    cdq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    cdq_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (in_data),
        .out_data (out_data)
    );

endmodule

FILE: rtl/cdq_ctrl.sv
module cdq_ctrl
    import cdq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    output cdq_cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        cmd.accept = (state_reg == S_IDLE) && in_valid;
        cmd.read   = (state_reg == S_READ);
        // Load the output register only when it is empty or being drained.
        cmd.load   = (state_reg == S_LOAD) && (!out_valid_reg || !out_stall);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.accept)
                    state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (cmd.load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/cdq_dp.sv
module cdq_dp
    import cdq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cdq_cmd_t   cmd,
    input  deque_in_t  in_data,
    output deque_out_t out_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic [AW-1:0]       head_reg;
    logic [AW-1:0]       head_next;
    logic [CW-1:0]       cnt_reg;
    logic [CW-1:0]       cnt_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [DATA_WIDTH-1:0] front_q;
    logic [DATA_WIDTH-1:0] back_q;
    deque_out_t          out_reg;

    logic                  full;
    logic                  empty;
    logic [AW-1:0]         head_dec;
    logic [AW-1:0]         head_inc;
    logic [AW:0]           tail_sum;
    logic [AW:0]           tail_wrap;
    logic [AW:0]           back_sum;
    logic [AW:0]           back_wrap;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [63:0]           val_wide;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [31:0]           cnt_wide;
    logic [63:0]           front_wide;
    logic [63:0]           back_wide;

    assign full  = (cnt_reg == CW'(DEPTH));
    assign empty = (cnt_reg == '0);

    assign head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);
    assign head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);

    // Unless empty, sums stay below 2*DEPTH; one subtract wraps them.
    assign tail_sum  = {1'b0, head_reg} + (AW+1)'(cnt_reg);
    assign tail_wrap = (tail_sum >= (AW+1)'(DEPTH)) ? tail_sum - (AW+1)'(DEPTH) : tail_sum;
    assign back_sum  = tail_sum - (AW+1)'(1);
    assign back_wrap = (back_sum >= (AW+1)'(DEPTH)) ? back_sum - (AW+1)'(DEPTH) : back_sum;

    assign val_wide = 64'(in_data.value);
    assign wr_data  = val_wide[DATA_WIDTH-1:0];

    always_comb
    begin
        head_next   = head_reg;
        cnt_next    = cnt_reg;
        status_next = ST_DONE;
        wr_en       = 1'b0;
        wr_addr     = head_dec;
        case (in_data.opcode)
            OP_PUSH_FRONT:
            begin
                if (full)
                    status_next = ST_FULL;
                else
                begin
                    head_next = head_dec;
                    wr_en     = cmd.accept;
                    wr_addr   = head_dec;
                    cnt_next  = cnt_reg + CW'(1);
                end
            end
            OP_PUSH_BACK:
            begin
                if (full)
                    status_next = ST_FULL;
                else
                begin
                    wr_en    = cmd.accept;
                    wr_addr  = tail_wrap[AW-1:0];
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            OP_POP_FRONT:
            begin
                if (empty)
                    status_next = ST_EMPTY;
                else
                begin
                    head_next = head_inc;
                    cnt_next  = cnt_reg - CW'(1);
                end
            end
            OP_POP_BACK:
            begin
                if (empty)
                    status_next = ST_EMPTY;
                else
                    cnt_next = cnt_reg - CW'(1);
            end
            default:
            begin
                status_next = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (cmd.accept)
        begin
            head_reg <= head_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            status_reg <= status_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.read)
        begin
            front_q <= mem[head_reg];
            back_q  <= mem[back_wrap[AW-1:0]];
        end
    end

    assign cnt_wide   = 32'(cnt_reg);
    assign front_wide = 64'(front_q);
    assign back_wide  = 64'(back_q);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_reg.status      <= status_reg;
            out_reg.count       <= cnt_wide[COUNT_W-1:0];
            // Report zeros when nothing is stored.
            out_reg.front_value <= empty ? '0 : front_wide[VALUE_W-1:0];
            out_reg.back_value  <= empty ? '0 : back_wide[VALUE_W-1:0];
        end
    end

    assign out_data = out_reg;

endmodule

FILE: rtl/cdq_checker.sv
`include "circular_deque_defines.svh"

module cdq_checker
    import cdq_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input deque_out_t out_data
);

    // A held result stays offered.
    `CDQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

    // One transaction at a time: busy right after an accept.
    `CDQ_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

    // An empty deque reports zero at both ends.
    `CDQ_ASSERT_IMPL(a_empty_zero, out_valid && out_data.count == '0,
        out_data.front_value == '0 && out_data.back_value == '0)

    // With one element, front and back are the same entry.
    `CDQ_ASSERT_IMPL(a_single_same, out_valid && out_data.count == COUNT_W'(1),
        out_data.front_value == out_data.back_value)

endmodule

bind circular_deque cdq_checker u_cdq_checker (.*);
